FILE: rtl/epsc_pkg.sv
// ----------------------------------------------------------------------------
// epsc_pkg
// Shared widths, reset values, register indexes and state codes for the
// encoder-fed PID speed controller.
// ----------------------------------------------------------------------------
package epsc_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int SPEED_WIDTH_DEF = 21;

  localparam int GAIN_W    = 16;
  localparam int WIN_W     = 16;
  localparam int TOP_W     = 16;
  localparam int RATE_W    = 32;
  localparam int TGT_W     = 21;
  localparam int PWM_W     = 16;
  localparam int FRAC_BITS = 8;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int SUM_W     = WIN_W + 1;
  localparam int PID_TERMS = 3;

  localparam int RPM_PER_HZ = 60;

  localparam logic [GAIN_W-1:0] GAIN_P_RST  = 16'd589;
  localparam logic [GAIN_W-1:0] GAIN_I_RST  = 16'd172;
  localparam logic [GAIN_W-1:0] GAIN_D_RST  = 16'd0;
  localparam logic [WIN_W-1:0]  WINDUP_RST  = 16'd1000;
  localparam logic [TOP_W-1:0]  TOP_RST     = 16'hFFFF;
  localparam logic [RATE_W-1:0] RATE_RST    = 32'd1000000;

  localparam logic MODE_TICK   = 1'b0;
  localparam logic MODE_TOGGLE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P    = 3'd0,
    REG_GAIN_I    = 3'd1,
    REG_GAIN_D    = 3'd2,
    REG_WINDUP    = 3'd3,
    REG_TOP       = 3'd4,
    REG_TICK_RATE = 3'd5
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SPEED,
    S_ERR,
    S_SUM,
    S_MAC,
    S_APPLY,
    S_DONE
  } ctl_state_t;

endpackage

FILE: rtl/epsc_if.sv
// ----------------------------------------------------------------------------
// epsc_if
// Valid/ready channels of the speed controller: input words and result words.
// ----------------------------------------------------------------------------
interface epsc_in_if import epsc_pkg::*; #(
  parameter int CW = COUNT_WIDTH_DEF
);
  logic                    valid;
  logic                    ready;
  logic                    mode;
  logic [CW-1:0]           encoder_count;
  logic signed [TGT_W-1:0] target_speed;
  logic                    direction;

  modport source (output valid, mode, encoder_count, target_speed, direction,
                  input ready);
  modport sink   (input valid, mode, encoder_count, target_speed, direction,
                  output ready);
endinterface

interface epsc_out_if import epsc_pkg::*; #(
  parameter int SW = SPEED_WIDTH_DEF
);
  logic             valid;
  logic             ready;
  logic [PWM_W-1:0] pwm_compare;
  logic             drive_in1;
  logic             drive_in2;
  logic             pwm_enabled;
  logic [SW-2:0]    measured_speed;
  logic             zero_interval;

  modport source (output valid, pwm_compare, drive_in1, drive_in2, pwm_enabled,
                  measured_speed, zero_interval, input ready);
  modport sink   (input valid, pwm_compare, drive_in1, drive_in2, pwm_enabled,
                  measured_speed, zero_interval, output ready);
endinterface

FILE: rtl/epsc_div.sv
// ----------------------------------------------------------------------------
// epsc_div
// Restoring divider, one quotient bit per cycle. When all NUM_W quotient bits
// are in, done pulses with the quotient in quo.
// ----------------------------------------------------------------------------
module epsc_div import epsc_pkg::*; #(
  parameter int NUM_W = RATE_W,
  parameter int DEN_W = COUNT_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_q;
  logic [NUM_W-1:0] dq;

  logic [DEN_W:0] r_shift;
  logic [DEN_W:0] trial;
  logic           ge;

  assign r_shift = {rem, dq[NUM_W-1]};
  assign trial   = r_shift - {1'b0, den_q};
  assign ge      = ~trial[DEN_W];
  assign quo     = dq;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // dividend shifts out the top while quotient bits shift in below
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      dq    <= num;
      den_q <= den;
    end else if (busy) begin
      dq  <= {dq[NUM_W-2:0], ge};
      rem <= ge ? trial[DEN_W-1:0] : r_shift[DEN_W-1:0];
    end
  end

endmodule

FILE: rtl/epsc_mac.sv
// ----------------------------------------------------------------------------
// epsc_mac
// Shift-add multiply-accumulate of three signed terms by three unsigned gains,
// one gain bit per cycle; done pulses once every gain bit of all PID_TERMS terms is in.
// ----------------------------------------------------------------------------
module epsc_mac import epsc_pkg::*; #(
  parameter int ACC_W = 41
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [ACC_W-1:0] x [PID_TERMS],
  input  logic [GAIN_W-1:0]       g [PID_TERMS],
  output logic                    done,
  output logic signed [ACC_W-1:0] acc
);

  localparam int TERM_W = $clog2(PID_TERMS);
  localparam int BIT_W  = $clog2(GAIN_W);

  logic                    busy;
  logic [TERM_W-1:0]       term;
  logic [BIT_W-1:0]        bitc;
  logic signed [ACC_W-1:0] mcand;
  logic [GAIN_W-1:0]       mult;
  logic [TERM_W-1:0]       term_nx;
  logic                    last_bit;
  logic                    last_term;

  assign term_nx   = term + 1'b1;
  assign last_bit  = (bitc == BIT_W'(GAIN_W - 1));
  assign last_term = (term == TERM_W'(PID_TERMS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      term <= '0;
      bitc <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        term <= '0;
        bitc <= '0;
      end else if (busy) begin
        bitc <= bitc + 1'b1;
        if (last_bit) begin
          bitc <= '0;
          if (last_term) begin
            busy <= 1'b0;
            done <= 1'b1;
          end else begin
            term <= term_nx;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc   <= '0;
      mcand <= x[0];
      mult  <= g[0];
    end else if (busy) begin
      if (mult[0]) begin
        acc <= acc + mcand;
      end
      if (last_bit && !last_term) begin
        mcand <= x[term_nx];
        mult  <= g[term_nx];
      end else begin
        mcand <= mcand <<< 1;
        mult  <= mult >> 1;
      end
    end
  end

endmodule

FILE: rtl/encoder_pid_speed_controller.sv
// ----------------------------------------------------------------------------
// encoder_pid_speed_controller
// Encoder speed measurement and PID speed loop driving a PWM compare value
// and H-bridge pins.
//
//   channel  | dir | word                                          | handshake
//   ---------+-----+-----------------------------------------------+----------
//   in_ch    | in  | mode, encoder_count, target_speed, direction  | valid/ready
//   out_ch   | out | pwm_compare, drive pins, pwm_enabled, speed,  | valid/ready
//            |     | zero_interval                                 |
//   cfg      | in  | cfg_we, cfg_addr, cfg_wdata                   | write only
//
// One word is processed at a time. A toggle goes straight to the apply and done
// states; a tick waits for the bit-serial divider, and a running tick with a
// nonzero target also waits for the shift-add multiplier, the two used in turn.
// A new word is taken while the previous result waits in the output register.
// Reset is synchronous and restores the register defaults and stopped state.
// ----------------------------------------------------------------------------
module encoder_pid_speed_controller import epsc_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
  parameter int SPEED_WIDTH = SPEED_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]     cfg_wdata,
  epsc_in_if.sink              in_ch,
  epsc_out_if.source           out_ch
);

  localparam int CW    = COUNT_WIDTH;
  localparam int SW    = SPEED_WIDTH;
  localparam int EW    = ((SW > TGT_W) ? SW : TGT_W) + 1;
  localparam int ACC_W = EW + GAIN_W + 3;
  localparam int SPEED_MAX = (1 << (SW - 1)) - 1;
  localparam int Q_SAT     = SPEED_MAX / RPM_PER_HZ;

  // configuration
  logic [GAIN_W-1:0] gain_p, gain_i, gain_d;
  logic [WIN_W-1:0]  windup_limit;
  logic [TOP_W-1:0]  counter_top;
  logic [RATE_W-1:0] tick_rate;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p       <= GAIN_P_RST;
      gain_i       <= GAIN_I_RST;
      gain_d       <= GAIN_D_RST;
      windup_limit <= WINDUP_RST;
      counter_top  <= TOP_RST;
      tick_rate    <= RATE_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_GAIN_P:    gain_p       <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_I:    gain_i       <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_D:    gain_d       <= cfg_wdata[GAIN_W-1:0];
        REG_WINDUP:    windup_limit <= cfg_wdata[WIN_W-1:0];
        REG_TOP:       counter_top  <= cfg_wdata[TOP_W-1:0];
        REG_TICK_RATE: tick_rate    <= cfg_wdata[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // control
  ctl_state_t state, state_next;
  logic       accept;
  logic       in_ready;

  // held word
  logic                    it_mode;
  logic [CW-1:0]           it_cnt;
  logic signed [TGT_W-1:0] it_tgt;
  logic                    it_dir;
  logic                    zflag;

  // loop state
  logic [CW-1:0]           last_count;
  logic [SW-2:0]           speed_reg;
  logic signed [EW-1:0]    err_now, err_before;
  logic signed [SUM_W-1:0] err_sum;
  logic [PWM_W-1:0]        compare_reg;
  logic                    pin_one, pin_two;
  logic                    halted;

  // output register
  logic             out_valid;
  logic [PWM_W-1:0] o_compare;
  logic             o_in1, o_in2, o_en, o_zero;
  logic [SW-2:0]    o_speed;

  // count difference with wrap correction
  logic [CW-1:0] top_c, diff;
  assign top_c = CW'(counter_top);
  assign diff  = (in_ch.encoder_count >= last_count) ?
                 (in_ch.encoder_count - last_count) :
                 (top_c - last_count + in_ch.encoder_count + CW'(1));

  assign in_ready    = (state == S_IDLE);
  assign in_ch.ready = in_ready;
  assign accept      = in_ch.valid && in_ready;

  // divider
  logic              div_start, div_done;
  logic [RATE_W-1:0] quo;
  assign div_start = accept && (in_ch.mode == MODE_TICK);

  epsc_div #(.NUM_W(RATE_W), .DEN_W(CW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (tick_rate),
    .den   (diff),
    .done  (div_done),
    .quo   (quo)
  );

  // speed from quotient
  logic [SW+5:0] spd_prod;
  logic [SW-2:0] speed_new;
  assign spd_prod  = (SW+6)'(quo[SW-1:0]) * (SW+6)'(RPM_PER_HZ);
  assign speed_new = (zflag || (quo > RATE_W'(Q_SAT))) ? (SW-1)'(SPEED_MAX)
                                                      : spd_prod[SW-2:0];

  // error terms
  logic signed [EW-1:0] e_new;
  logic signed [EW:0]   s_raw, lim_s;
  assign e_new = EW'(it_tgt) - EW'($signed({1'b0, speed_reg}));
  assign s_raw = (EW+1)'(err_sum) + (EW+1)'(err_now);
  assign lim_s = $signed((EW+1)'(windup_limit));

  // multiply-accumulate
  logic                    mac_go, mac_done;
  logic signed [ACC_W-1:0] mac_x [PID_TERMS];
  logic [GAIN_W-1:0]       mac_g [PID_TERMS];
  logic signed [ACC_W-1:0] acc;

  assign mac_x[0] = ACC_W'(err_now);
  assign mac_x[1] = ACC_W'(err_sum);
  assign mac_x[2] = ACC_W'(err_now) - ACC_W'(err_before);
  assign mac_g[0] = gain_p;
  assign mac_g[1] = gain_i;
  assign mac_g[2] = gain_d;

  epsc_mac #(.ACC_W(ACC_W)) u_mac (
    .clk   (clk),
    .rst   (rst),
    .start (mac_go),
    .x     (mac_x),
    .g     (mac_g),
    .done  (mac_done),
    .acc   (acc)
  );

  // Q8.8 scale, truncated, clamped to 0..65535
  logic             acc_pos;
  logic [PWM_W-1:0] pwm_new;
  assign acc_pos = !acc[ACC_W-1] && (|acc);
  always_comb begin
    if (!acc_pos) begin
      pwm_new = '0;
    end else if (|acc[ACC_W-1:PWM_W+FRAC_BITS]) begin
      pwm_new = '1;
    end else begin
      pwm_new = acc[PWM_W+FRAC_BITS-1:FRAC_BITS];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (in_ch.mode == MODE_TOGGLE) ? S_APPLY : S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_next = S_SPEED;
        end
      end
      S_SPEED: begin
        state_next = (halted || (it_tgt == '0)) ? S_APPLY : S_ERR;
      end
      S_ERR:   state_next = S_SUM;
      S_SUM:   state_next = S_MAC;
      S_MAC: begin
        if (mac_done) begin
          state_next = S_APPLY;
        end
      end
      S_APPLY: state_next = S_DONE;
      S_DONE: begin
        if (!out_valid || out_ch.ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      mac_go <= 1'b0;
    end else begin
      state  <= state_next;
      mac_go <= (state == S_SUM);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      it_mode <= in_ch.mode;
      it_cnt  <= in_ch.encoder_count;
      it_tgt  <= in_ch.target_speed;
      it_dir  <= in_ch.direction;
      zflag   <= (in_ch.mode == MODE_TICK) && (diff == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_count  <= '0;
      speed_reg   <= '0;
      err_now     <= '0;
      err_before  <= '0;
      err_sum     <= '0;
      compare_reg <= '0;
      pin_one     <= 1'b0;
      pin_two     <= 1'b0;
      halted      <= 1'b1;
    end else begin
      unique case (state)
        S_SPEED: speed_reg <= speed_new;
        S_ERR: begin
          err_before <= err_now;
          err_now    <= e_new;
        end
        S_SUM: begin
          if (s_raw > lim_s) begin
            err_sum <= SUM_W'(lim_s);
          end else if (s_raw < -lim_s) begin
            err_sum <= SUM_W'(-lim_s);
          end else begin
            err_sum <= SUM_W'(s_raw);
          end
        end
        S_MAC: begin
          if (mac_done) begin
            compare_reg <= pwm_new;
          end
        end
        S_APPLY: begin
          if (it_mode == MODE_TOGGLE) begin
            if (!halted) begin
              halted  <= 1'b1;
              pin_one <= 1'b0;
              pin_two <= 1'b0;
            end else begin
              last_count <= it_cnt;
              halted     <= 1'b0;
            end
          end else begin
            last_count <= it_cnt;
            if (!halted) begin
              if (it_tgt == '0) begin
                err_now     <= '0;
                err_before  <= '0;
                err_sum     <= '0;
                compare_reg <= '0;
              end
              pin_one <= it_dir;
              pin_two <= !it_dir;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // output register
  logic out_load;
  assign out_load = (state == S_DONE) && (!out_valid || out_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_compare <= compare_reg;
      o_in1     <= pin_one;
      o_in2     <= pin_two;
      o_en      <= !halted;
      o_speed   <= speed_reg;
      o_zero    <= zflag;
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.pwm_compare    = o_compare;
  assign out_ch.drive_in1      = o_in1;
  assign out_ch.drive_in2      = o_in2;
  assign out_ch.pwm_enabled    = o_en;
  assign out_ch.measured_speed = o_speed;
  assign out_ch.zero_interval  = o_zero;

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("input taken while a word is in progress");

  a_stopped_pins_low: assert property (@(posedge clk) disable iff (rst)
    halted |-> !(pin_one || pin_two))
    else $error("bridge pins driven while stopped");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider finished outside its wait state");

  a_mac_done_state: assert property (@(posedge clk) disable iff (rst)
    mac_done |-> (state == S_MAC))
    else $error("multiplier finished outside its wait state");
`endif

endmodule

FILE: verif/encoder_pid_speed_controller_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// encoder_pid_speed_controller_tb
// Drives control ticks and stop/go toggles into the speed controller and
// predicts every result word (speed, compare value, bridge pins, flags) with
// a local model of the control law. Covers directed corners, register
// extremes, output backpressure and long random traffic with random stalls.
// ----------------------------------------------------------------------------
module encoder_pid_speed_controller_tb import epsc_pkg::*; ();

  typedef struct packed {
    logic                       mode;
    logic [COUNT_WIDTH_DEF-1:0] count;
    logic [TGT_W-1:0]           target;
    logic                       dir;
  } ctl_word_t;

  typedef struct packed {
    logic [PWM_W-1:0]           compare;
    logic                       in1;
    logic                       in2;
    logic                       enabled;
    logic [SPEED_WIDTH_DEF-2:0] speed;
    logic                       zero;
  } drive_word_t;

  localparam longint unsigned COUNT_MASK = (64'd1 << COUNT_WIDTH_DEF) - 1;
  localparam longint SPEED_SAT = (64'sd1 << (SPEED_WIDTH_DEF - 1)) - 1;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_addr;
  logic [CFG_W-1:0] cfg_wdata;

  epsc_in_if  in_ch ();
  epsc_out_if out_ch ();

  encoder_pid_speed_controller i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // controller registers as seen by the predictor
  logic [GAIN_W-1:0] kp, ki, kd;
  logic [WIN_W-1:0]  windup;
  logic [TOP_W-1:0]  wrap_top;
  logic [RATE_W-1:0] tick_rate;

  // controller state as seen by the predictor
  logic [COUNT_WIDTH_DEF-1:0]   enc_last;
  logic [SPEED_WIDTH_DEF-1:0]   speed_now;
  logic signed [TGT_W:0]        err_now;
  logic signed [SUM_W-1:0]      err_acc;
  logic [PWM_W-1:0]             compare_now;
  logic                         pin_a, pin_b;
  logic                         stopped;

  drive_word_t expected_drive_q[$];
  int mismatch_count = 0;
  int idle_pct = 0;
  int hold_cycles = 0;

  function automatic void reset_controller();
    kp = GAIN_P_RST;
    ki = GAIN_I_RST;
    kd = GAIN_D_RST;
    windup = WINDUP_RST;
    wrap_top = TOP_RST;
    tick_rate = RATE_RST;
    enc_last = '0;
    speed_now = '0;
    err_now = '0;
    err_acc = '0;
    compare_now = '0;
    pin_a = 1'b0;
    pin_b = 1'b0;
    stopped = 1'b1;
  endfunction

  function automatic drive_word_t advance_controller(input ctl_word_t w);
    longint unsigned span, rpm;
    longint tgt, err, sum, lim, total;
    drive_word_t r;
    r.zero = 1'b0;
    if (w.mode == MODE_TICK) begin
      if (w.count >= enc_last)
        span = 64'(w.count) - 64'(enc_last);
      else
        span = (64'(wrap_top) - 64'(enc_last) + 64'(w.count) + 1) & COUNT_MASK;
      enc_last = w.count;
      if (span == 0) begin
        r.zero = 1'b1;
        speed_now = SPEED_WIDTH_DEF'(SPEED_SAT);
      end else begin
        rpm = (64'(tick_rate) / span) * RPM_PER_HZ;
        speed_now = (rpm > SPEED_SAT) ? SPEED_WIDTH_DEF'(SPEED_SAT)
                                      : SPEED_WIDTH_DEF'(rpm);
      end
      if (!stopped) begin
        tgt = longint'($signed(w.target));
        if (tgt != 0) begin
          err = tgt - longint'(speed_now);
          sum = longint'(err_acc) + err;
          lim = longint'(windup);
          if (sum > lim) sum = lim;
          if (sum < -lim) sum = -lim;
          // derivative term uses the previous error before it is replaced
          total = err * longint'(kp) + sum * longint'(ki)
                + (err - longint'(err_now)) * longint'(kd);
          err_now = (TGT_W+1)'(err);
          err_acc = SUM_W'(sum);
          if (total <= 0) begin
            compare_now = '0;
          end else begin
            total = total >> FRAC_BITS;
            compare_now = (total > 65535) ? 16'hFFFF : 16'(total);
          end
        end else begin
          err_now = '0;
          err_acc = '0;
          compare_now = '0;
        end
        pin_a = w.dir;
        pin_b = ~w.dir;
      end
    end else if (!stopped) begin
      stopped = 1'b1;
      pin_a = 1'b0;
      pin_b = 1'b0;
    end else begin
      enc_last = w.count;
      stopped = 1'b0;
    end
    r.compare = compare_now;
    r.in1 = pin_a;
    r.in2 = pin_b;
    r.enabled = ~stopped;
    r.speed = speed_now[SPEED_WIDTH_DEF-2:0];
    return r;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  function automatic ctl_word_t make_word(input logic mode, input int cnt, input int tgt,
                                          input logic dir);
    ctl_word_t w;
    w.mode = mode;
    w.count = COUNT_WIDTH_DEF'(cnt);
    w.target = TGT_W'(tgt);
    w.dir = dir;
    return w;
  endfunction

  // mostly a running motor with plausible count steps and targets
  function automatic ctl_word_t random_word();
    ctl_word_t w;
    int r;
    r = $urandom_range(0, 99);
    if (stopped) w.mode = (r < 50) ? MODE_TOGGLE : MODE_TICK;
    else w.mode = (r < 3) ? MODE_TOGGLE : MODE_TICK;
    r = $urandom_range(0, 99);
    if (r < 70) w.count = enc_last + COUNT_WIDTH_DEF'($urandom_range(1, 3000));
    else if (r < 78) w.count = enc_last;
    else if (r < 85) w.count = enc_last + COUNT_WIDTH_DEF'($urandom_range(1, 8));
    else w.count = COUNT_WIDTH_DEF'($urandom);
    r = $urandom_range(0, 99);
    if (r < 10) w.target = '0;
    else if (r < 70) w.target = TGT_W'(int'($urandom_range(0, 200000)) - 100000);
    else if (r < 85)
      w.target = TGT_W'(int'(speed_now) + int'($urandom_range(0, 2000)) - 1000);
    else w.target = TGT_W'($urandom);
    w.dir = 1'($urandom_range(0, 1));
    return w;
  endfunction

  function automatic logic [15:0] pick_reg16(input int typical_max);
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return 16'd0;
    if (r < 30) return 16'hFFFF;
    if (r < 70) return 16'($urandom_range(0, typical_max));
    return 16'($urandom);
  endfunction

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_GAIN_P:    kp = val[GAIN_W-1:0];
      REG_GAIN_I:    ki = val[GAIN_W-1:0];
      REG_GAIN_D:    kd = val[GAIN_W-1:0];
      REG_WINDUP:    windup = val[WIN_W-1:0];
      REG_TOP:       wrap_top = val[TOP_W-1:0];
      REG_TICK_RATE: tick_rate = val[RATE_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_word(input ctl_word_t w);
    in_ch.valid <= 1'b1;
    in_ch.mode <= w.mode;
    in_ch.encoder_count <= w.count;
    in_ch.target_speed <= w.target;
    in_ch.direction <= w.dir;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    expected_drive_q.push_back(advance_controller(w));
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat (gap_len()) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_drive_q.size() != 0);
  endtask

  // unused upper data bits are random on the 16-bit registers
  task automatic random_setup();
    write_reg(REG_GAIN_P, {16'($urandom), pick_reg16(1024)});
    write_reg(REG_GAIN_I, {16'($urandom), pick_reg16(512)});
    write_reg(REG_GAIN_D, {16'($urandom), pick_reg16(256)});
    write_reg(REG_WINDUP, {16'($urandom), pick_reg16(5000)});
    write_reg(REG_TOP, {16'($urandom),
                        ($urandom_range(0, 99) < 70) ? 16'hFFFF : 16'($urandom)});
    case ($urandom_range(0, 9))
      0:       write_reg(REG_TICK_RATE, 32'd1);
      1:       write_reg(REG_TICK_RATE, 32'hFFFF_FFFF);
      2, 3, 4, 5: write_reg(REG_TICK_RATE, RATE_RST);
      default: write_reg(REG_TICK_RATE, $urandom);
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  // result checker
  initial begin
    drive_word_t want;
    forever begin
      @(posedge clk);
      if (rst === 1'b0 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (expected_drive_q.size() == 0) begin
          mismatch_count++;
          $error("result word with nothing expected");
        end else begin
          want = expected_drive_q.pop_front();
          check_field("pwm_compare", want.compare, out_ch.pwm_compare);
          check_field("drive_in1", want.in1, out_ch.drive_in1);
          check_field("drive_in2", want.in2, out_ch.drive_in2);
          check_field("pwm_enabled", want.enabled, out_ch.pwm_enabled);
          check_field("measured_speed", want.speed, out_ch.measured_speed);
          check_field("zero_interval", want.zero, out_ch.zero_interval);
        end
      end
    end
  end

  // result ready: random stalls plus an occasional long hold
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_cycles != 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        out_ch.ready <= 1'b0;
        repeat (gap_len()) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic test_halted_start();
    send_word(make_word(MODE_TICK, 100, 5000, 1'b1));        // tick while stopped
    send_word(make_word(MODE_TOGGLE, 65535, 0, 1'b0));       // start, latch count
    send_word(make_word(MODE_TICK, 65535, 1048575, 1'b1));   // no movement
    send_word(make_word(MODE_TICK, 10, -1048576, 1'b0));     // counter wrap
    send_word(make_word(MODE_TICK, 20, 0, 1'b1));            // zero target
    send_word(make_word(MODE_TICK, 520, 3000, 1'b1));
    send_word(make_word(MODE_TICK, 1020, 3000, 1'b0));
  endtask

  task automatic test_stop_restart();
    send_word(make_word(MODE_TOGGLE, 5, 0, 1'b1));
    send_word(make_word(MODE_TICK, 900, 3000, 1'b1));
    send_word(make_word(MODE_TOGGLE, 0, 0, 1'b0));
    send_word(make_word(MODE_TICK, 0, 1, 1'b1));
    send_word(make_word(MODE_TICK, 30000, 60000, 1'b1));
    drain_results();
  endtask

  task automatic test_register_corners();
    write_reg(REG_TOP, 32'd1000);
    send_word(make_word(MODE_TICK, 5000, 2000, 1'b1));       // count above top
    send_word(make_word(MODE_TICK, 64000, 2000, 1'b1));
    send_word(make_word(MODE_TICK, 62999, 2000, 1'b0));      // wraps to zero span
    drain_results();
    write_reg(REG_TICK_RATE, 32'd0);
    send_word(make_word(MODE_TICK, 63500, 2000, 1'b1));
    drain_results();
    write_reg(REG_TICK_RATE, 32'hFFFF_FFFF);
    write_reg(REG_TOP, 32'hFFFF);
    write_reg(REG_GAIN_P, 32'hFFFF);
    write_reg(REG_GAIN_I, 32'hFFFF);
    write_reg(REG_GAIN_D, 32'hFFFF);
    write_reg(REG_WINDUP, 32'hFFFF);
    send_word(make_word(MODE_TICK, 63501, 1048575, 1'b1));
    send_word(make_word(MODE_TICK, 100, -1048576, 1'b0));
    send_word(make_word(MODE_TICK, 200, 1048575, 1'b1));
    drain_results();
    write_reg(REG_GAIN_P, 32'd0);
    write_reg(REG_GAIN_I, 32'd0);
    write_reg(REG_GAIN_D, 32'd0);
    write_reg(REG_WINDUP, 32'd0);
    send_word(make_word(MODE_TICK, 1200, 50000, 1'b1));
    drain_results();
    write_reg(REG_GAIN_P, CFG_W'(GAIN_P_RST));
    write_reg(REG_GAIN_I, CFG_W'(GAIN_I_RST));
    write_reg(REG_GAIN_D, 32'd300);
    write_reg(REG_WINDUP, CFG_W'(WINDUP_RST));
    write_reg(REG_TICK_RATE, RATE_RST);
  endtask

  task automatic test_output_backpressure();
    drain_results();
    idle_pct = 0;
    hold_cycles = 400;
    repeat (12) send_word(random_word());
    drain_results();
  endtask

  task automatic test_random_traffic();
    int sel;
    for (int phase = 0; phase < 10; phase++) begin
      drain_results();
      if (phase != 0 && $urandom_range(0, 3) != 0) random_setup();
      sel = $urandom_range(0, 2);
      idle_pct = (sel == 0) ? 0 : (sel == 1) ? 15 : 40;
      repeat (150) send_word(random_word());
    end
  endtask

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_addr <= REG_GAIN_P;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.mode <= MODE_TICK;
    in_ch.encoder_count <= '0;
    in_ch.target_speed <= '0;
    in_ch.direction <= 1'b0;
    reset_controller();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    idle_pct = 30;
    test_halted_start();
    test_stop_restart();
    test_register_corners();
    test_output_backpressure();
    test_random_traffic();
    drain_results();
    repeat (100) @(posedge clk);
    if (mismatch_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
